// File: hdl/figle_pkg.sv
// ----------------------------------------------------------------------------
// figle_pkg: shared types and constants of the gate list evaluator
// Gate entry layout, front-to-back queue item, register indexes and the
// sequencer states of the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package figle_pkg;

   // primary input vector and net file geometry
   localparam int INPUT_W   = 16;
   localparam int IDX_W     = 7;
   localparam int NET_COUNT = 128;
   localparam int BRIDGE_W  = 4;
   localparam int COUNT_W   = 8;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // action code of the input item
   localparam logic ACTION_EVAL = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STUCK_LOW  = 3'd0,
      CSR_STUCK_HIGH = 3'd1,
      CSR_AND_TARGET = 3'd2,
      CSR_AND_PARTNER = 3'd3,
      CSR_OR_TARGET  = 3'd4,
      CSR_OR_PARTNER = 3'd5,
      CSR_OP_COUNT   = 3'd6
   } csr_index_type;

   // one stored gate entry, lsb first: src1, src2, kind, destination
   typedef struct packed {
      logic             dest_invert;
      logic [IDX_W-1:0] dest_index;
      logic             gate_is_or;
      logic             src2_invert;
      logic [IDX_W-1:0] src2_index;
      logic             src2_is_input;
      logic             src1_invert;
      logic [IDX_W-1:0] src1_index;
      logic             src1_is_input;
   } gate_word_type;

   localparam int GATE_W = $bits(gate_word_type);

   // fault settings seen by the front end
   typedef struct packed {
      logic [INPUT_W-1:0]  stuck_low;
      logic [INPUT_W-1:0]  stuck_high;
      logic [BRIDGE_W-1:0] and_target;
      logic [BRIDGE_W-1:0] and_partner;
      logic [BRIDGE_W-1:0] or_target;
      logic [BRIDGE_W-1:0] or_partner;
   } fault_cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic               is_eval;
      logic               load_en;
      logic [IDX_W-1:0]   entry_index;
      gate_word_type      word;
      logic [INPUT_W-1:0] fault_vector;
   } queue_item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

// File: hdl/figle_ram.sv
// ----------------------------------------------------------------------------
// figle_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module figle_ram #(
   parameter int WIDTH  = 1,
   parameter int DEPTH  = 2,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/figle_queue.sv
// ----------------------------------------------------------------------------
// figle_queue: short queue between front and back
// Holds classified items so that the front keeps taking beats while the
// back works through a gate list.
// ----------------------------------------------------------------------------
`default_nettype none

module figle_queue
   import figle_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  queue_item_type push_item,
   output logic           full,
   input  logic           pop,
   output queue_item_type head_item,
   output logic           head_valid
);

   queue_item_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: hdl/figle_front.sv
// ----------------------------------------------------------------------------
// figle_front: request intake and classification
// Takes request beats, packs gate entries for loads, and builds the faulted
// input vector (stuck masks, then AND bridge, then OR bridge) for evaluates.
// ----------------------------------------------------------------------------
`default_nettype none

module figle_front
   import figle_pkg::*;
#(
   parameter int MAX_OPS    = 128,
   parameter int NUM_INPUTS = 16
) (
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [IDX_W-1:0]   req_entry_index,
   input  logic               req_src1_is_input,
   input  logic [IDX_W-1:0]   req_src1_index,
   input  logic               req_src1_invert,
   input  logic               req_src2_is_input,
   input  logic [IDX_W-1:0]   req_src2_index,
   input  logic               req_src2_invert,
   input  logic               req_gate_is_or,
   input  logic [IDX_W-1:0]   req_dest_index,
   input  logic               req_dest_invert,
   input  logic [INPUT_W-1:0] req_input_vector,
   input  fault_cfg_type      fault_cfg,
   input  logic               q_full,
   output logic               q_push,
   output queue_item_type     q_item
);

   // input bits that exist in this configuration
   localparam logic [INPUT_W-1:0] INPUT_SPAN = (NUM_INPUTS >= INPUT_W) ?
      {INPUT_W{1'b1}} : INPUT_W'((64'd1 << NUM_INPUTS) - 64'd1);

   logic [INPUT_W-1:0] fault_vector;

   always_comb begin
      fault_vector = ((req_input_vector & fault_cfg.stuck_low) | fault_cfg.stuck_high)
                     & INPUT_SPAN;
      if (32'(fault_cfg.and_target) < NUM_INPUTS) begin
         fault_vector[fault_cfg.and_target] = fault_vector[fault_cfg.and_target]
                                              & fault_vector[fault_cfg.and_partner];
      end
      if (32'(fault_cfg.or_target) < NUM_INPUTS) begin
         fault_vector[fault_cfg.or_target] = fault_vector[fault_cfg.or_target]
                                             | fault_vector[fault_cfg.or_partner];
      end
   end

   always_comb begin
      q_item.is_eval             = (req_action == ACTION_EVAL);
      q_item.load_en             = (32'(req_entry_index) < MAX_OPS);
      q_item.entry_index         = req_entry_index;
      q_item.word.src1_is_input  = req_src1_is_input;
      q_item.word.src1_index     = req_src1_index;
      q_item.word.src1_invert    = req_src1_invert;
      q_item.word.src2_is_input  = req_src2_is_input;
      q_item.word.src2_index     = req_src2_index;
      q_item.word.src2_invert    = req_src2_invert;
      q_item.word.gate_is_or     = req_gate_is_or;
      q_item.word.dest_index     = req_dest_index;
      q_item.word.dest_invert    = req_dest_invert;
      q_item.fault_vector        = fault_vector;
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

`default_nettype wire

// File: hdl/figle_back.sv
// ----------------------------------------------------------------------------
// figle_back: gate program store and gate list sequencer
// Writes loaded entries, and for an evaluate fetches one gate per cycle,
// reads both operand nets, computes and writes the destination net.
// ----------------------------------------------------------------------------
`default_nettype none

module figle_back
   import figle_pkg::*;
#(
   parameter int MAX_OPS    = 128,
   parameter int NUM_INPUTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  queue_item_type     q_item,
   output logic               q_pop,
   input  logic [COUNT_W-1:0] op_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_function_value
);

   localparam int PA_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;

   back_state_type     state_ff, state_in;
   logic [COUNT_W-1:0] op_limit;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [INPUT_W-1:0] xin_ff, xin_in;
   logic               last_ff, last_in;
   logic               r_vld_ff, x_vld_ff;
   gate_word_type      x_word_ff;
   logic               fw_vld_ff, fw_vld_in;
   logic [IDX_W-1:0]   fw_dest_ff, fw_dest_in;
   logic               fw_val_ff, fw_val_in;
   logic [NET_COUNT-1:0] net_vld_ff, net_vld_in;
   logic               va_vld_ff, vb_vld_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_val_ff, rsp_val_in;

   logic               start_eval;
   logic               prog_we;
   logic               issue;
   logic               finish;
   logic [PA_W-1:0]    prog_raddr;
   logic [GATE_W-1:0]  prog_rdata;
   gate_word_type      r_word;
   logic [0:0]         net_a_rdata, net_b_rdata;
   logic               opnd_a, opnd_b, gate_z;

   // op_count saturates at the program depth
   assign op_limit = (32'(op_count) > MAX_OPS) ? COUNT_W'(MAX_OPS) : op_count;
   assign r_word   = gate_word_type'(prog_rdata);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && q_item.is_eval) begin
               state_in = (op_limit == '0) ? BK_DONE : BK_RUN;
            end
         end
         BK_RUN: begin
            if (idx_ff == n_ff && !r_vld_ff && !x_vld_ff) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (finish) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      q_pop      = 1'b0;
      prog_we    = 1'b0;
      issue      = 1'b0;
      finish     = 1'b0;
      start_eval = 1'b0;
      prog_raddr = PA_W'(idx_ff);
      unique case (state_ff)
         BK_IDLE: begin
            prog_raddr = '0;
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.is_eval) begin
                  start_eval = 1'b1;
                  issue      = (op_limit != '0);
               end else begin
                  prog_we = q_item.load_en;
               end
            end
         end
         BK_RUN: begin
            issue = (idx_ff < n_ff);
         end
         BK_DONE: begin
            finish = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            issue = 1'b0;
         end
      endcase
   end

   // operands, with a bypass from the most recently written gate
   always_comb begin
      if (x_word_ff.src1_is_input) begin
         opnd_a = (32'(x_word_ff.src1_index) < NUM_INPUTS && 32'(x_word_ff.src1_index) < INPUT_W)
                  ? xin_ff[x_word_ff.src1_index[BRIDGE_W-1:0]] : 1'b0;
      end else if (fw_vld_ff && fw_dest_ff == x_word_ff.src1_index) begin
         opnd_a = fw_val_ff;
      end else begin
         opnd_a = va_vld_ff & net_a_rdata[0];
      end
      if (x_word_ff.src2_is_input) begin
         opnd_b = (32'(x_word_ff.src2_index) < NUM_INPUTS && 32'(x_word_ff.src2_index) < INPUT_W)
                  ? xin_ff[x_word_ff.src2_index[BRIDGE_W-1:0]] : 1'b0;
      end else if (fw_vld_ff && fw_dest_ff == x_word_ff.src2_index) begin
         opnd_b = fw_val_ff;
      end else begin
         opnd_b = vb_vld_ff & net_b_rdata[0];
      end
      opnd_a = opnd_a ^ x_word_ff.src1_invert;
      opnd_b = opnd_b ^ x_word_ff.src2_invert;
      gate_z = (x_word_ff.gate_is_or ? (opnd_a | opnd_b) : (opnd_a & opnd_b))
               ^ x_word_ff.dest_invert;
   end

   // datapath next values
   always_comb begin
      idx_in     = idx_ff;
      n_in       = n_ff;
      xin_in     = xin_ff;
      last_in    = last_ff;
      fw_vld_in  = fw_vld_ff;
      fw_dest_in = fw_dest_ff;
      fw_val_in  = fw_val_ff;
      net_vld_in = net_vld_ff;
      if (start_eval) begin
         idx_in  = COUNT_W'(1);
         n_in    = op_limit;
         xin_in  = q_item.fault_vector;
         last_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end
      if (x_vld_ff) begin
         last_in    = gate_z;
         fw_vld_in  = 1'b1;
         fw_dest_in = x_word_ff.dest_index;
         fw_val_in  = gate_z;
         net_vld_in[x_word_ff.dest_index] = 1'b1;
      end
      rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);
      rsp_val_in   = finish ? last_ff : rsp_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         r_vld_ff     <= 1'b0;
         x_vld_ff     <= 1'b0;
         fw_vld_ff    <= 1'b0;
         net_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         r_vld_ff     <= issue;
         x_vld_ff     <= r_vld_ff;
         fw_vld_ff    <= fw_vld_in;
         net_vld_ff   <= net_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      xin_ff     <= xin_in;
      last_ff    <= last_in;
      x_word_ff  <= r_word;
      fw_dest_ff <= fw_dest_in;
      fw_val_ff  <= fw_val_in;
      va_vld_ff  <= net_vld_ff[r_word.src1_index];
      vb_vld_ff  <= net_vld_ff[r_word.src2_index];
      rsp_val_ff <= rsp_val_in;
   end

   figle_ram #(
      .WIDTH (GATE_W),
      .DEPTH (MAX_OPS)
   ) u_prog_ram (
      .clock   (clock),
      .wr_en   (prog_we),
      .wr_addr (PA_W'(q_item.entry_index)),
      .wr_data (q_item.word),
      .rd_addr (prog_raddr),
      .rd_data (prog_rdata)
   );

   // two copies of the net file, one per operand read
   figle_ram #(
      .WIDTH (1),
      .DEPTH (NET_COUNT)
   ) u_net_ram_a (
      .clock   (clock),
      .wr_en   (x_vld_ff),
      .wr_addr (x_word_ff.dest_index),
      .wr_data (gate_z),
      .rd_addr (r_word.src1_index),
      .rd_data (net_a_rdata)
   );

   figle_ram #(
      .WIDTH (1),
      .DEPTH (NET_COUNT)
   ) u_net_ram_b (
      .clock   (clock),
      .wr_en   (x_vld_ff),
      .wr_addr (x_word_ff.dest_index),
      .wr_data (gate_z),
      .rd_addr (r_word.src2_index),
      .rd_data (net_b_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_function_value = rsp_val_ff;

endmodule

`default_nettype wire

// File: hdl/fault_injected_gate_list_evaluator_core.sv
// ----------------------------------------------------------------------------
// fault_injected_gate_list_evaluator_core: gate list evaluator with faults
// Usage:
// - req_* channel (valid/stall): a beat with req_action low loads one gate
//   entry; a beat with req_action high evaluates req_input_vector.
// - rsp_* channel (valid/stall): one beat per evaluate, carrying the value
//   stored by the last gate run (zero when op_count is zero). Loads give
//   no response beat.
// - csr_* channel (valid/ready): fault masks, bridges and op_count; always
//   ready; written by the user only while the block is idle, not enforced.
// - Sequencing: an evaluate runs its gates through the gate fetch / net read
//   pipeline, one gate per clock through the program memory and the net
//   memories, and its result is registered once the last gate is written;
//   the next queued item is taken only after that. A load is written to the
//   program memory straight from the idle state.
// - A two-beat queue sits between intake and sequencer, so requests keep
//   being taken while the sequencer runs or a result waits on rsp_stall.
// - A stalled result holds in the output register; the sequencer then
//   waits in its done state, and req_stall rises once the queue fills.
// - Reset (synchronous) clears the registers to their defaults, all nets
//   to zero and empties the queue; the gate program keeps its old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_injected_gate_list_evaluator_core
   import figle_pkg::*;
#(
   parameter int MAX_OPS    = 128,
   parameter int NUM_INPUTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [IDX_W-1:0]       req_entry_index,
   input  logic                   req_src1_is_input,
   input  logic [IDX_W-1:0]       req_src1_index,
   input  logic                   req_src1_invert,
   input  logic                   req_src2_is_input,
   input  logic [IDX_W-1:0]       req_src2_index,
   input  logic                   req_src2_invert,
   input  logic                   req_gate_is_or,
   input  logic [IDX_W-1:0]       req_dest_index,
   input  logic                   req_dest_invert,
   input  logic [INPUT_W-1:0]     req_input_vector,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_function_value,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   fault_cfg_type      fault_cfg_ff, fault_cfg_in;
   logic [COUNT_W-1:0] op_count_ff, op_count_in;
   logic               csr_write;

   logic               q_full;
   logic               q_push;
   queue_item_type     q_push_item;
   logic               q_pop;
   queue_item_type     q_head_item;
   logic               q_head_valid;

   // register writes: always ready, unknown indexes are dropped
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      fault_cfg_in = fault_cfg_ff;
      op_count_in  = op_count_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_STUCK_LOW:   fault_cfg_in.stuck_low   = csr_data[INPUT_W-1:0];
            CSR_STUCK_HIGH:  fault_cfg_in.stuck_high  = csr_data[INPUT_W-1:0];
            CSR_AND_TARGET:  fault_cfg_in.and_target  = csr_data[BRIDGE_W-1:0];
            CSR_AND_PARTNER: fault_cfg_in.and_partner = csr_data[BRIDGE_W-1:0];
            CSR_OR_TARGET:   fault_cfg_in.or_target   = csr_data[BRIDGE_W-1:0];
            CSR_OR_PARTNER:  fault_cfg_in.or_partner  = csr_data[BRIDGE_W-1:0];
            CSR_OP_COUNT:    op_count_in              = csr_data[COUNT_W-1:0];
            default:         op_count_in              = op_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_cfg_ff.stuck_low   <= {INPUT_W{1'b1}};
         fault_cfg_ff.stuck_high  <= '0;
         fault_cfg_ff.and_target  <= '0;
         fault_cfg_ff.and_partner <= '0;
         fault_cfg_ff.or_target   <= '0;
         fault_cfg_ff.or_partner  <= '0;
         op_count_ff              <= '0;
      end else begin
         fault_cfg_ff <= fault_cfg_in;
         op_count_ff  <= op_count_in;
      end
   end

   // intake: classify the beat and apply input faults
   figle_front #(
      .MAX_OPS    (MAX_OPS),
      .NUM_INPUTS (NUM_INPUTS)
   ) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_entry_index   (req_entry_index),
      .req_src1_is_input (req_src1_is_input),
      .req_src1_index    (req_src1_index),
      .req_src1_invert   (req_src1_invert),
      .req_src2_is_input (req_src2_is_input),
      .req_src2_index    (req_src2_index),
      .req_src2_invert   (req_src2_invert),
      .req_gate_is_or    (req_gate_is_or),
      .req_dest_index    (req_dest_index),
      .req_dest_invert   (req_dest_invert),
      .req_input_vector  (req_input_vector),
      .fault_cfg         (fault_cfg_ff),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_item            (q_push_item)
   );

   // decoupling queue
   figle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_item  (q_head_item),
      .head_valid (q_head_valid)
   );

   // sequencer: program store, net file and result register
   figle_back #(
      .MAX_OPS    (MAX_OPS),
      .NUM_INPUTS (NUM_INPUTS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_head_valid),
      .q_item             (q_head_item),
      .q_pop              (q_pop),
      .op_count           (op_count_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_function_value (rsp_function_value)
   );

endmodule

`default_nettype wire

// File: hdl/figle_checker.sv
// ----------------------------------------------------------------------------
// figle_checker: port-level checks of the evaluator
// Response channel holding rules and reset behavior of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module figle_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_function_value
);

   // a stalled result beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // a stalled result beat keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_function_value))
      else $error("rsp value changed while stalled");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // reset empties the queue, so intake is open right after
   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("req stalled after reset");

endmodule

bind fault_injected_gate_list_evaluator_core figle_checker u_figle_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_function_value (rsp_function_value)
);

`default_nettype wire
